### src/websocket_frame_deframer_macros.svh
// Assertion macros used by the deframer top level.
`ifndef WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define WSD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define WSD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/wsd_pkg.sv
// Shared types and constants of the WebSocket frame deframer.
package wsd_pkg;

	localparam int unsigned ByteW   = 8;
	localparam int unsigned OpcodeW = 4;
	localparam int unsigned LenW    = 64;
	localparam int unsigned KeyW    = 32;
	localparam int unsigned HdrCntW = 4;

	localparam logic [OpcodeW-1:0] FWD_OPCODE_RST = 4'h1;
	localparam logic [6:0]         LEN7_EXT16     = 7'd126;
	localparam logic [6:0]         LEN7_EXT64     = 7'd127;
	localparam logic [HdrCntW-1:0] EXT16_BYTES    = 4'd2;
	localparam logic [HdrCntW-1:0] EXT64_BYTES    = 4'd8;
	localparam logic [HdrCntW-1:0] KEY_BYTES      = 4'd4;

	typedef enum logic [2:0] {
		PH_FIRST,
		PH_SECOND,
		PH_EXTLEN,
		PH_KEY,
		PH_PAYLOAD
	} phase_t;

	typedef struct packed {
		logic             valid;
		logic [ByteW-1:0] data;
		logic             last;
	} wsd_res_t;

	typedef struct packed {
		phase_t phase;
		logic   rem_zero;
	} wsd_stat_t;

endpackage

### src/wsd_parser.sv
// Frame header parser, length tracking and payload unmasking for one byte per cycle while fire is high.
module wsd_parser import wsd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  logic [ByteW-1:0]   rx_byte,
	input  logic [OpcodeW-1:0] fwd_opcode,
	output wsd_res_t           res,
	output wsd_stat_t          stat
);

	phase_t               phase_q, phase_d;
	logic [OpcodeW-1:0]   opcode_q;
	logic                 masked_q;
	logic [LenW-1:0]      rem_q, rem_d;
	logic [HdrCntW-1:0]   hdr_left_q, hdr_left_d;
	logic [KeyW-1:0]      key_q;
	logic [1:0]           key_idx_q;
	logic [6:0]           len7;
	logic [HdrCntW-1:0]   hdr_dec;
	logic                 hdr_done;
	logic [ByteW-1:0]     key_byte;
	logic                 rem_le1;

	assign len7     = rx_byte[6:0];
	assign hdr_dec  = (hdr_left_q != '0) ? hdr_left_q - 1'b1 : '0;
	assign hdr_done = (hdr_dec == '0);
	assign rem_le1  = (rem_q[LenW-1:1] == '0);

	always_comb begin
		unique case (key_idx_q)
			2'd0: key_byte = key_q[31:24];
			2'd1: key_byte = key_q[23:16];
			2'd2: key_byte = key_q[15:8];
			2'd3: key_byte = key_q[7:0];
			default: key_byte = key_q[7:0];
		endcase
	end

	// Length and header counter updates feed the phase decision.
	always_comb begin
		rem_d      = rem_q;
		hdr_left_d = hdr_left_q;
		unique case (phase_q)
			PH_SECOND: begin
				if (len7 == LEN7_EXT16) begin
					rem_d      = '0;
					hdr_left_d = EXT16_BYTES;
				end else if (len7 == LEN7_EXT64) begin
					rem_d      = '0;
					hdr_left_d = EXT64_BYTES;
				end else begin
					rem_d      = {{(LenW-7){1'b0}}, len7};
					hdr_left_d = rx_byte[7] ? KEY_BYTES : hdr_left_q;
				end
			end
			PH_EXTLEN: begin
				rem_d      = {rem_q[LenW-ByteW-1:0], rx_byte};
				hdr_left_d = (hdr_done && masked_q) ? KEY_BYTES : hdr_dec;
			end
			PH_KEY: begin
				hdr_left_d = hdr_dec;
			end
			PH_PAYLOAD: begin
				rem_d = (rem_q != '0) ? rem_q - 1'b1 : '0;
			end
			default: begin
			end
		endcase
	end

	// Next phase.
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_SECOND: begin
				if (len7 == LEN7_EXT16 || len7 == LEN7_EXT64)
					phase_d = PH_EXTLEN;
				else if (rx_byte[7])
					phase_d = PH_KEY;
				else if (len7 == '0)
					phase_d = PH_FIRST;
				else
					phase_d = PH_PAYLOAD;
			end
			PH_EXTLEN: begin
				if (hdr_done) begin
					if (masked_q)
						phase_d = PH_KEY;
					else if (rem_d == '0)
						phase_d = PH_FIRST;
					else
						phase_d = PH_PAYLOAD;
				end
			end
			PH_KEY: begin
				if (hdr_done)
					phase_d = (rem_q == '0) ? PH_FIRST : PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				if (rem_le1)
					phase_d = PH_FIRST;
			end
			default: phase_d = PH_SECOND;
		endcase
	end

	// Outputs: a result only for payload bytes of the selected opcode.
	always_comb begin
		res.valid = fire && (phase_q == PH_PAYLOAD) && (opcode_q == fwd_opcode);
		res.data  = rx_byte ^ key_byte;
		res.last  = rem_le1;
		stat.phase    = phase_q;
		stat.rem_zero = (rem_q == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_FIRST;
			opcode_q   <= '0;
			masked_q   <= 1'b0;
			rem_q      <= '0;
			hdr_left_q <= '0;
			key_q      <= '0;
			key_idx_q  <= '0;
		end else if (fire) begin
			phase_q    <= phase_d;
			rem_q      <= rem_d;
			hdr_left_q <= hdr_left_d;
			unique case (phase_q)
				PH_SECOND: begin
					masked_q  <= rx_byte[7];
					key_q     <= '0;
					key_idx_q <= '0;
				end
				PH_EXTLEN: begin
				end
				PH_KEY: begin
					key_q <= {key_q[KeyW-ByteW-1:0], rx_byte};
				end
				PH_PAYLOAD: begin
					key_idx_q <= key_idx_q + 2'd1;
				end
				default: begin
					opcode_q <= rx_byte[OpcodeW-1:0];
				end
			endcase
		end
	end

endmodule

### src/websocket_frame_deframer.sv
// Top level of the WebSocket frame deframer: input stage, result register, config.
//
//   channel  | handshake            | payload
//   ---------+----------------------+----------------------------
//   input    | in_valid / in_stall  | in_byte
//   output   | out_valid / out_stall| payload_byte, end_of_frame
//   config   | cfg_wr_en            | cfg_wr_data (forward opcode)
//
// One byte is accepted per cycle unless in_stall is high; a byte passes the input register, then the result register.
// The input register and the result register each hold one transaction, so one
// byte is still taken while a result waits on a stalled output.
// Reset clears all frame state; the forward opcode resets to text.
// Header bytes and skipped payload bytes give no result.
module websocket_frame_deframer import wsd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [ByteW-1:0]   in_byte,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [ByteW-1:0]   payload_byte,
	output logic               end_of_frame,
	input  logic               cfg_wr_en,
	input  logic [OpcodeW-1:0] cfg_wr_data
);

	`include "websocket_frame_deframer_macros.svh"

	logic               valid_s1;
	logic [ByteW-1:0]   byte_s1;
	logic               out_valid_q;
	logic [ByteW-1:0]   out_byte_q;
	logic               out_last_q;
	logic [OpcodeW-1:0] fwd_opcode_q;
	logic               advance;
	logic               fire;
	wsd_res_t           res;
	wsd_stat_t          stat;

	assign advance  = !out_valid_q || !out_stall;
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_opcode_q <= FWD_OPCODE_RST;
		end else if (cfg_wr_en) begin
			fwd_opcode_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall) begin
			byte_s1 <= in_byte;
		end
	end

	wsd_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.rx_byte    (byte_s1),
		.fwd_opcode (fwd_opcode_q),
		.res        (res),
		.stat       (stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_byte_q <= res.data;
			out_last_q <= res.last;
		end
	end

	assign out_valid    = out_valid_q;
	assign payload_byte = out_byte_q;
	assign end_of_frame = out_last_q;

	// A frame's last byte in the result register means the parser has gone back
	// to waiting for a header.
	`WSD_ASSERT_NOW(a_eof_phase, out_valid_q && out_last_q, stat.phase == PH_FIRST, "eof without return to header phase")
	// The payload phase always has at least one byte left to go.
	`WSD_ASSERT_NOW(a_payload_len, stat.phase == PH_PAYLOAD, !stat.rem_zero, "payload phase with zero length")
	// The input only stalls while a result is held back by the output.
	`WSD_ASSERT_NOW(a_stall_cause, in_stall, out_valid_q && out_stall && valid_s1, "input stall without output stall")
	// A byte that is taken is processed in the next cycle unless the output stalls.
	`WSD_ASSERT_NEXT(a_input_moves, in_valid && !in_stall, valid_s1, "accepted byte lost")

endmodule
